@@ rtl/rbas_pkg.sv @@
// Shared types, register indexes and constant functions of the radial bubble alpha shader.
// No dependencies; rbas_log2, rbas_exp2 and the top level import it.
package rbas_pkg;

	typedef enum logic [1:0] {SEL_CALC, SEL_ZERO, SEL_FULL} sel_t;

	typedef struct packed {
		logic vld;
		sel_t sel;
	} ctl_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_RED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAD   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RHO   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CX    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CY    = 3'd6;

	localparam int FRAC_W = 16;

	function automatic logic [63:0] isqrt_c(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] x;
		int j;
		r = '0;
		x = v;
		for (j = 0; j < 32; j++) begin
			b = 64'd1 << (62 - 2 * j);
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	// 2^(-2^-i) in Q0.32, built by repeated square roots
	function automatic logic [31:0] exp_const(input int i);
		logic [63:0] c;
		int k;
		c = isqrt_c(64'h8000_0000_0000_0000);
		for (k = 1; k < i; k++) begin
			c = isqrt_c(c << 32);
		end
		return c[31:0];
	endfunction

endpackage

@@ rtl/rbas_if.sv @@
// Pixel stream interfaces: coordinate words in, colour and alpha words out.
// Depends on nothing.
interface rbas_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] x_pos;
	logic [15:0] y_pos;
	modport source (output valid, x_pos, y_pos, input ready);
	modport sink (input valid, x_pos, y_pos, output ready);
endinterface

interface rbas_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [15:0] alpha;
	modport source (output valid, red, green, blue, alpha, input ready);
	modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

@@ rtl/rbas_log2.sv @@
// Pipelined log2 in Q.16: msb search, normalize, then one squaring step per stage.
// Depends on rbas_pkg.
module rbas_log2 #(
	parameter int N_W = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  rbas_pkg::ctl_t            ctl_i,
	input  logic [N_W-1:0]            n_i,
	output rbas_pkg::ctl_t            ctl_o,
	output logic [$clog2(N_W)+15:0]   log_o
);
	import rbas_pkg::*;

	localparam int K_W = $clog2(N_W);
	localparam int NS  = FRAC_W;
	localparam int LST = NS + 2;

	ctl_t               ctl_s [1:LST];
	logic [N_W-1:0]     n_s1;
	logic [K_W-1:0]     k_s   [1:LST];
	logic [30:0]        m_s   [2:LST];
	logic [FRAC_W-1:0]  f_s   [2:LST];
	logic [K_W-1:0]     k_c;
	logic [N_W+29:0]    sh_c;

	always_comb begin
		k_c = '0;
		for (int i = 0; i < N_W; i++) begin
			if (n_i[i]) k_c = K_W'(i);
		end
	end

	assign sh_c = {n_s1, 30'd0} >> k_s[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[1] <= '0;
			ctl_s[2] <= '0;
		end else if (en) begin
			ctl_s[1] <= ctl_i;
			ctl_s[2] <= ctl_s[1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1     <= n_i;
			k_s[1]   <= k_c;
			k_s[2]   <= k_s[1];
			m_s[2]   <= sh_c[30:0];
			f_s[2]   <= '0;
		end
	end

	for (genvar g = 0; g < NS; g++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] m2;
		assign sq = {31'd0, m_s[g+2]} * {31'd0, m_s[g+2]};
		assign m2 = sq[61:30];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) ctl_s[g+3] <= '0;
			else if (en) ctl_s[g+3] <= ctl_s[g+2];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				k_s[g+3] <= k_s[g+2];
				if (m2[31]) begin
					m_s[g+3] <= m2[31:1];
					f_s[g+3] <= {f_s[g+2][FRAC_W-2:0], 1'b1};
				end else begin
					m_s[g+3] <= m2[30:0];
					f_s[g+3] <= {f_s[g+2][FRAC_W-2:0], 1'b0};
				end
			end
		end
	end

	assign ctl_o = ctl_s[LST];
	assign log_o = {k_s[LST], f_s[LST]};

endmodule

@@ rtl/rbas_exp2.sv @@
// Pipelined 2^(-e) for Q.16 e into Q1.32: one constant multiply per fraction bit, then shift.
// Depends on rbas_pkg.
module rbas_exp2 #(
	parameter int E_W = 22
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  rbas_pkg::ctl_t ctl_i,
	input  logic [E_W-1:0] e_i,
	output rbas_pkg::ctl_t ctl_o,
	output logic [32:0]    v_o
);
	import rbas_pkg::*;

	localparam int NS = FRAC_W;

	ctl_t           ctl_s [0:NS+1];
	logic [32:0]    v_s   [0:NS];
	logic [E_W-1:0] e_s   [0:NS];
	logic [32:0]    out_s;

	assign ctl_s[0] = ctl_i;
	assign v_s[0]   = 33'h1_0000_0000;
	assign e_s[0]   = e_i;

	for (genvar g = 0; g < NS; g++) begin : g_mul
		localparam logic [31:0] C = exp_const(g + 1);
		logic [64:0] prod;
		assign prod = {32'd0, v_s[g]} * {33'd0, C};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) ctl_s[g+1] <= '0;
			else if (en) ctl_s[g+1] <= ctl_s[g];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				e_s[g+1] <= e_s[g];
				v_s[g+1] <= e_s[g][FRAC_W-1-g] ? prod[64:32] : v_s[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s[NS+1] <= '0;
		else if (en) ctl_s[NS+1] <= ctl_s[NS];
	end

	always_ff @(posedge clk) begin
		if (en) out_s <= v_s[NS] >> e_s[NS][E_W-1:FRAC_W];
	end

	assign ctl_o = ctl_s[NS+1];
	assign v_o   = out_s;

endmodule

@@ rtl/radial_bubble_alpha_shader.sv @@
// Radial bubble alpha shader: top level with distance, divides and power chain.
// Depends on rbas_pkg, rbas_if, rbas_log2 and rbas_exp2.
// Stages: the square root gives one result bit a stage, and the two long divisions one quotient bit a stage.
// Throughput: one word per cycle; the whole pipe holds on a stalled output.
// Reset: clears all valid bits and loads the register reset values.
module radial_bubble_alpha_shader #(
	parameter int COORD_FRAC_BITS = 15
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rbas_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [rbas_pkg::CFG_DATA_W-1:0]    cfg_data,
	rbas_in_if.sink                            pix_in,
	rbas_out_if.source                         pix_out
);
	import rbas_pkg::*;

	localparam int S      = 32 - COORD_FRAC_BITS;
	localparam int DIFF_W = ((16 + S > 34) ? 16 + S : 34) + 1;
	localparam int MAG_W  = DIFF_W - 16;
	localparam int SQ_W   = 2 * MAG_W + 1;
	localparam int NB     = MAG_W + 1;
	localparam int DV1    = 16;
	localparam int DV2    = 38;

	logic [7:0]  red_q, green_q, blue_q;
	logic [15:0] rad_q, rho_q, cx_q, cy_q;
	logic [16:0] rho16_q;
	logic [32:0] rho_prod;
	logic        en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
			rad_q   <= 16'h8000;
			rho_q   <= 16'h8000;
			cx_q    <= 16'h8000;
			cy_q    <= 16'h8000;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_RED:   red_q   <= cfg_data[7:0];
				REG_GREEN: green_q <= cfg_data[7:0];
				REG_BLUE:  blue_q  <= cfg_data[7:0];
				REG_RAD:   rad_q   <= cfg_data;
				REG_RHO:   rho_q   <= cfg_data;
				REG_CX:    cx_q    <= cfg_data;
				REG_CY:    cy_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rho_prod = {16'd0, 17'd85197} * {17'd0, rho_q} + 33'd32768;

	always_ff @(posedge clk) begin
		rho16_q <= rho_prod[32:16] + 17'd19661;
	end

	// front end: offsets, magnitudes, squares
	ctl_t                ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [DIFF_W-1:0]   dx_s1, dy_s1, ax_s2, ay_s2;
	logic [MAG_W-1:0]    mx_s3, my_s3;
	logic [2*MAG_W-1:0]  sqx_s4, sqy_s4;
	logic signed [17:0]  cxs, cys;
	logic [DIFF_W-1:0]   cxw, cyw, pxw, pyw, rx, ry;

	assign cxs = $signed({1'b0, cx_q, 1'b0}) - 18'sd65536;
	assign cys = $signed({1'b0, cy_q, 1'b0}) - 18'sd65536;
	assign cxw = {{(DIFF_W-34){cxs[17]}}, cxs, 16'd0};
	assign cyw = {{(DIFF_W-34){cys[17]}}, cys, 16'd0};
	assign pxw = {{(DIFF_W-16-S){pix_in.x_pos[15]}}, pix_in.x_pos, {S{1'b0}}};
	assign pyw = {{(DIFF_W-16-S){pix_in.y_pos[15]}}, pix_in.y_pos, {S{1'b0}}};
	assign rx  = ax_s2 + DIFF_W'(32768);
	assign ry  = ay_s2 + DIFF_W'(32768);

	ctl_t              qc [0:NB];
	logic [SQ_W-1:0]   qx [0:NB];
	logic [SQ_W-1:0]   qr [0:NB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			qc[0]  <= '0;
		end else if (en) begin
			ctl_s1 <= '{vld: pix_in.valid, sel: SEL_CALC};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			qc[0]  <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= cxw - pxw;
			dy_s1  <= cyw - pyw;
			ax_s2  <= dx_s1[DIFF_W-1] ? -dx_s1 : dx_s1;
			ay_s2  <= dy_s1[DIFF_W-1] ? -dy_s1 : dy_s1;
			mx_s3  <= rx[DIFF_W-1:16];
			my_s3  <= ry[DIFF_W-1:16];
			sqx_s4 <= {MAG_W'(0), mx_s3} * {MAG_W'(0), mx_s3};
			sqy_s4 <= {MAG_W'(0), my_s3} * {MAG_W'(0), my_s3};
			qx[0]  <= {1'b0, sqx_s4} + {1'b0, sqy_s4};
			qr[0]  <= '0;
		end
	end

	// square root, one result bit a stage
	for (genvar j = 0; j < NB; j++) begin : g_sqrt
		localparam logic [SQ_W-1:0] B = SQ_W'(1) << (2 * (NB - 1 - j));
		logic [SQ_W-1:0] rb;
		assign rb = qr[j] + B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) qc[j+1] <= '0;
			else if (en) qc[j+1] <= qc[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (qx[j] >= rb) begin
					qx[j+1] <= qx[j] - rb;
					qr[j+1] <= (qr[j] >> 1) + B;
				end else begin
					qx[j+1] <= qx[j];
					qr[j+1] <= qr[j] >> 1;
				end
			end
		end
	end

	// range check, then d = rad_dist * 2^16 / r
	ctl_t        dc [0:DV1];
	logic [15:0] dr [0:DV1];
	logic [15:0] dq [0:DV1];
	logic [NB-1:0] rad_dist;
	logic        outside;

	assign rad_dist = qr[NB][NB-1:0];
	assign outside  = (rad_q == '0) || (rad_dist >= NB'(rad_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dc[0] <= '0;
		else if (en) dc[0] <= '{vld: qc[NB].vld, sel: outside ? SEL_ZERO : qc[NB].sel};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dr[0] <= rad_dist[15:0];
			dq[0] <= '0;
		end
	end

	for (genvar j = 0; j < DV1; j++) begin : g_div1
		logic [16:0] t;
		logic [16:0] td;
		logic        ge;
		assign t  = {dr[j], 1'b0};
		assign ge = t >= {1'b0, rad_q};
		assign td = t - {1'b0, rad_q};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dc[j+1] <= '0;
			else if (en) dc[j+1] <= dc[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dr[j+1] <= ge ? td[15:0] : t[15:0];
				dq[j+1] <= {dq[j][14:0], ge};
			end
		end
	end

	// d^rho
	ctl_t        ld_ci, ld_co;
	logic [19:0] log_d;

	assign ld_ci = '{vld: dc[DV1].vld,
		sel: (dc[DV1].sel == SEL_CALC && dq[DV1] == '0) ? SEL_FULL : dc[DV1].sel};

	rbas_log2 #(.N_W(16)) u_log_d (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (ld_ci),
		.n_i    (dq[DV1]),
		.ctl_o  (ld_co),
		.log_o  (log_d)
	);

	ctl_t        ctl_l, ctl_p;
	logic [20:0] l_q;
	logic [21:0] p_q;
	logic [37:0] lp_prod;

	assign lp_prod = {17'd0, l_q} * {21'd0, rho16_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_l <= '0;
			ctl_p <= '0;
		end else if (en) begin
			ctl_l <= ld_co;
			ctl_p <= ctl_l;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_q <= 21'h10_0000 - {1'b0, log_d};
			p_q <= lp_prod[37:16];
		end
	end

	ctl_t        eu_co;
	logic [32:0] u;

	rbas_exp2 #(.E_W(22)) u_exp_u (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (ctl_p),
		.e_i    (p_q),
		.ctl_o  (eu_co),
		.v_o    (u)
	);

	// (1 - d^rho)^(1/rho)
	ctl_t        ctl_w;
	logic [32:0] w_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_w <= '0;
		else if (en) ctl_w <= '{vld: eu_co.vld,
			sel: (eu_co.sel == SEL_CALC && u == 33'h1_0000_0000) ? SEL_ZERO : eu_co.sel};
	end

	always_ff @(posedge clk) begin
		if (en) w_q <= 33'h1_0000_0000 - u;
	end

	ctl_t        lw_co;
	logic [21:0] log_w;

	rbas_log2 #(.N_W(33)) u_log_w (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (ctl_w),
		.n_i    (w_q),
		.ctl_o  (lw_co),
		.log_o  (log_w)
	);

	ctl_t            qc2 [0:DV2];
	logic [16:0]     qr2 [0:DV2];
	logic [DV2-1:0]  nq  [0:DV2];
	logic [21:0]     m_c;

	assign m_c = 22'h20_0000 - log_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) qc2[0] <= '0;
		else if (en) qc2[0] <= lw_co;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qr2[0] <= '0;
			nq[0]  <= {m_c, 16'd0};
		end
	end

	for (genvar j = 0; j < DV2; j++) begin : g_div2
		logic [17:0] t;
		logic [17:0] td;
		logic        ge;
		assign t  = {qr2[j], nq[j][DV2-1]};
		assign ge = t >= {1'b0, rho16_q};
		assign td = t - {1'b0, rho16_q};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) qc2[j+1] <= '0;
			else if (en) qc2[j+1] <= qc2[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				qr2[j+1] <= ge ? td[16:0] : t[16:0];
				nq[j+1]  <= {nq[j][DV2-2:0], ge};
			end
		end
	end

	ctl_t        ea_co;
	logic [32:0] va;

	rbas_exp2 #(.E_W(DV2)) u_exp_a (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (qc2[DV2]),
		.e_i    (nq[DV2]),
		.ctl_o  (ea_co),
		.v_o    (va)
	);

	// round, saturate, select
	ctl_t        ctl_o;
	logic [15:0] alpha_o;
	logic [33:0] va_rnd;
	logic [15:0] alpha_c;

	assign va_rnd = {1'b0, va} + 34'd32768;

	always_comb begin
		case (ea_co.sel)
			SEL_ZERO: alpha_c = '0;
			SEL_FULL: alpha_c = 16'hFFFF;
			default:  alpha_c = (|va_rnd[33:32]) ? 16'hFFFF : va_rnd[31:16];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_o <= '0;
		else if (en) ctl_o <= ea_co;
	end

	always_ff @(posedge clk) begin
		if (en) alpha_o <= alpha_c;
	end

	assign en            = !ctl_o.vld || pix_out.ready;
	assign pix_in.ready  = en;
	assign pix_out.valid = ctl_o.vld;
	assign pix_out.alpha = alpha_o;
	assign pix_out.red   = red_q;
	assign pix_out.green = green_q;
	assign pix_out.blue  = blue_q;

endmodule
